@@ rtl/core/ss_pkg.sv @@
`default_nettype none
package ss_pkg;

   localparam int VALUE_W = 32;

   // microprogram step numbers
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] S_LOAD    = 4'd0;
   localparam logic [STEP_W-1:0] S_INIT    = 4'd1;
   localparam logic [STEP_W-1:0] S_OUTER   = 4'd2;
   localparam logic [STEP_W-1:0] S_HOLD    = 4'd3;
   localparam logic [STEP_W-1:0] S_CMP     = 4'd4;
   localparam logic [STEP_W-1:0] S_PLACE   = 4'd5;
   localparam logic [STEP_W-1:0] S_NEXTGAP = 4'd6;
   localparam logic [STEP_W-1:0] S_EMIT_RD = 4'd7;
   localparam logic [STEP_W-1:0] S_EMIT_LD = 4'd8;
   localparam logic [STEP_W-1:0] S_DONE    = 4'd9;

   // datapath operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_LOAD    = 4'd0;
   localparam logic [OP_W-1:0] OP_INIT    = 4'd1;
   localparam logic [OP_W-1:0] OP_FETCH   = 4'd2;
   localparam logic [OP_W-1:0] OP_HOLD    = 4'd3;
   localparam logic [OP_W-1:0] OP_SHIFT   = 4'd4;
   localparam logic [OP_W-1:0] OP_PLACE   = 4'd5;
   localparam logic [OP_W-1:0] OP_HALVE   = 4'd6;
   localparam logic [OP_W-1:0] OP_EMIT_RD = 4'd7;
   localparam logic [OP_W-1:0] OP_EMIT_LD = 4'd8;
   localparam logic [OP_W-1:0] OP_DONE    = 4'd9;

   // jump conditions
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] C_ALWAYS     = 3'd0;
   localparam logic [COND_W-1:0] C_ACC_LAST   = 3'd1;
   localparam logic [COND_W-1:0] C_N_ONE      = 3'd2;
   localparam logic [COND_W-1:0] C_I_LT_N     = 3'd3;
   localparam logic [COND_W-1:0] C_SHIFT_MORE = 3'd4;
   localparam logic [COND_W-1:0] C_GAP_ONE    = 3'd5;
   localparam logic [COND_W-1:0] C_OUT_FREE   = 3'd6;
   localparam logic [COND_W-1:0] C_K_LAST     = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic              inv;
      logic [STEP_W-1:0] target;
   } ss_ctl_type;

   typedef struct packed {
      logic acc_last;
      logic n_one;
      logic i_lt_n;
      logic shift_more;
      logic gap_one;
      logic out_free;
      logic k_last;
      logic gap_nz;
   } ss_flag_type;

   // control store: jump to target when (cond ^ inv), else fall through
   function automatic ss_ctl_type ss_rom(input logic [STEP_W-1:0] step);
      ss_ctl_type w;
      unique case (step)
         S_LOAD:    w = '{OP_LOAD,    C_ACC_LAST,   1'b1, S_LOAD};
         S_INIT:    w = '{OP_INIT,    C_N_ONE,      1'b0, S_EMIT_RD};
         S_OUTER:   w = '{OP_FETCH,   C_I_LT_N,     1'b1, S_NEXTGAP};
         S_HOLD:    w = '{OP_HOLD,    C_ALWAYS,     1'b0, S_CMP};
         S_CMP:     w = '{OP_SHIFT,   C_SHIFT_MORE, 1'b0, S_CMP};
         S_PLACE:   w = '{OP_PLACE,   C_ALWAYS,     1'b0, S_OUTER};
         S_NEXTGAP: w = '{OP_HALVE,   C_GAP_ONE,    1'b1, S_OUTER};
         S_EMIT_RD: w = '{OP_EMIT_RD, C_OUT_FREE,   1'b1, S_EMIT_RD};
         S_EMIT_LD: w = '{OP_EMIT_LD, C_K_LAST,     1'b1, S_EMIT_RD};
         S_DONE:    w = '{OP_DONE,    C_ALWAYS,     1'b0, S_LOAD};
         default:   w = '{OP_DONE,    C_ALWAYS,     1'b0, S_LOAD};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/ss_req_if.sv @@
`default_nettype none
interface ss_req_if import ss_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      last;

   modport source(output valid, output value, output last, input ready);
   modport sink(input valid, input value, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ss_rsp_if.sv @@
`default_nettype none
interface ss_rsp_if import ss_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] sorted_value;
   logic                      final_res;

   modport source(output valid, output sorted_value, output final_res, input ready);
   modport sink(input valid, input sorted_value, input final_res, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ss_seq.sv @@
`default_nettype none
module ss_seq import ss_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ss_flag_type flag,
   output ss_ctl_type       ctl
);

   logic [STEP_W-1:0] upc_ff;
   logic [STEP_W-1:0] upc_in;
   logic              cond_hit;

   assign ctl = ss_rom(upc_ff);

   always_comb begin
      unique case (ctl.cond)
         C_ALWAYS:     cond_hit = 1'b1;
         C_ACC_LAST:   cond_hit = flag.acc_last;
         C_N_ONE:      cond_hit = flag.n_one;
         C_I_LT_N:     cond_hit = flag.i_lt_n;
         C_SHIFT_MORE: cond_hit = flag.shift_more;
         C_GAP_ONE:    cond_hit = flag.gap_one;
         C_OUT_FREE:   cond_hit = flag.out_free;
         C_K_LAST:     cond_hit = flag.k_last;
         default:      cond_hit = 1'b1;
      endcase
      upc_in = (cond_hit ^ ctl.inv) ? ctl.target : upc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_LOAD;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/ss_dpath.sv @@
`default_nettype none
module ss_dpath import ss_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ss_ctl_type                ctl,
   output ss_flag_type                    flag,
   input  wire logic                      req_valid,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire logic                      req_last,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [VALUE_W-1:0]      rsp_sorted_value,
   output logic                           rsp_final_res
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = CW + 1;

   logic signed [VALUE_W-1:0] store_ff [CAPACITY];

   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [AW-1:0]             gap_ff, gap_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic [AW-1:0]             pos_ff, pos_in;
   logic [AW-1:0]             k_ff, k_in;
   logic signed [VALUE_W-1:0] held_ff, held_in;
   logic signed [VALUE_W-1:0] rdata_ff;
   logic signed [VALUE_W-1:0] out_value_ff, out_value_in;
   logic                      out_final_ff, out_final_in;
   logic                      out_valid_ff, out_valid_in;

   logic                      we;
   logic [AW-1:0]             wa;
   logic signed [VALUE_W-1:0] wd;
   logic [AW-1:0]             ra;

   logic                      not_full;
   logic                      shift;
   logic                      pos2ok;
   logic                      k_last;
   logic [AW-1:0]             pos_m_gap;
   logic [AW-1:0]             pos_m_2gap;

   assign not_full   = cnt_ff < CW'(CAPACITY);
   assign shift      = rdata_ff > held_ff;
   assign pos2ok     = {1'b0, pos_ff} >= {gap_ff, 1'b0};
   assign pos_m_gap  = pos_ff - gap_ff;
   assign pos_m_2gap = pos_ff - AW'({gap_ff, 1'b0});
   assign k_last     = (CW'(k_ff) + CW'(1)) == cnt_ff;

   assign flag.acc_last   = req_valid && req_last;
   assign flag.n_one      = cnt_ff[CW-1:1] == '0;
   assign flag.i_lt_n     = idx_ff < IW'(cnt_ff);
   assign flag.shift_more = shift && pos2ok;
   assign flag.gap_one    = gap_ff == AW'(1);
   assign flag.out_free   = !out_valid_ff || rsp_ready;
   assign flag.k_last     = k_last;
   assign flag.gap_nz     = gap_ff != '0;

   assign req_ready        = ctl.op == OP_LOAD;
   assign rsp_valid        = out_valid_ff;
   assign rsp_sorted_value = out_value_ff;
   assign rsp_final_res    = out_final_ff;

   always_comb begin
      cnt_in       = cnt_ff;
      gap_in       = gap_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      held_in      = held_ff;
      out_value_in = out_value_ff;
      out_final_in = out_final_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      we           = 1'b0;
      wa           = pos_ff;
      wd           = held_ff;
      ra           = '0;
      unique case (ctl.op)
         OP_LOAD: begin
            wa = cnt_ff[AW-1:0];
            wd = req_value;
            if (req_valid && not_full) begin
               we     = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         OP_INIT: begin
            gap_in = AW'(cnt_ff >> 1);
            idx_in = IW'(cnt_ff >> 1);
            k_in   = '0;
         end
         OP_FETCH: begin
            ra     = idx_ff[AW-1:0];
            pos_in = idx_ff[AW-1:0];
         end
         OP_HOLD: begin
            held_in = rdata_ff;
            ra      = pos_m_gap;
         end
         OP_SHIFT: begin
            // move the larger neighbor up one gap and look one gap further down
            ra = pos_m_2gap;
            wd = rdata_ff;
            if (shift) begin
               we     = 1'b1;
               pos_in = pos_m_gap;
            end
         end
         OP_PLACE: begin
            // subsequences are interleaved, so stepping by one visits all of them
            we     = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         OP_HALVE: begin
            gap_in = gap_ff >> 1;
            idx_in = IW'(gap_ff >> 1);
         end
         OP_EMIT_RD: begin
            ra = k_ff;
         end
         OP_EMIT_LD: begin
            out_value_in = rdata_ff;
            out_final_in = k_last;
            out_valid_in = 1'b1;
            k_in         = k_ff + 1'b1;
         end
         OP_DONE: begin
            cnt_in = '0;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[wa] <= wd;
      end
      rdata_ff <= store_ff[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      gap_ff       <= gap_in;
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      k_ff         <= k_in;
      held_ff      <= held_in;
      out_value_ff <= out_value_in;
      out_final_ff <= out_final_in;
   end

endmodule
`default_nettype wire

@@ rtl/core/shell_sort.sv @@
// shell_sort: collects a set of signed 32-bit values and returns them in
// ascending order.
// req_ch carries one value per transaction; the transaction with last set
// closes the set. Up to CAPACITY values are kept, later ones are dropped.
// loading takes one cycle per transaction, with ready held high while loading.
// after the closing transaction a microcoded sequencer sorts the store by
// shell sort with gaps n/2, n/4 .. 1. each insertion fetches the element,
// holds it, moves each larger neighbor up one gap until a compare meets a
// value that is not larger or the start of its subsequence, then places it;
// each gap ends in a halving step. the store takes one read and one write per cycle.
// results then leave on rsp_ch, each from an emit read and an emit load
// step, the last one with final_res set; a done step then ends the set.
// rsp_ch has an output register: a stalled receiver holds the sequencer in
// its emit step, and no new values are taken until the last result of the
// set sits in the output register.
// reset clears the element count and the output valid and returns the
// sequencer to loading; the store itself is not cleared.
`default_nettype none
module shell_sort import ss_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   ss_req_if.sink    req_ch,
   ss_rsp_if.source  rsp_ch
);

   ss_ctl_type  seq_ctl;
   ss_flag_type dp_flag;

   ss_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flag  (dp_flag),
      .ctl   (seq_ctl)
   );

   ss_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (seq_ctl),
      .flag             (dp_flag),
      .req_valid        (req_ch.valid),
      .req_value        (req_ch.value),
      .req_last         (req_ch.last),
      .req_ready        (req_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_sorted_value (rsp_ch.sorted_value),
      .rsp_final_res    (rsp_ch.final_res)
   );

   // closing transaction starts the sort
   a_close_starts_sort: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && req_ch.last |=> seq_ctl.op == OP_INIT)
      else $error("sort did not start after closing transaction");

   // a new result only comes from the emit load step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(seq_ctl.op == OP_EMIT_LD))
      else $error("result appeared outside emit");

   // emit never overwrites a pending result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      seq_ctl.op == OP_EMIT_LD |-> !rsp_ch.valid)
      else $error("pending result overwritten");

   // compare and place steps only run with a nonzero gap
   a_gap_nonzero: assert property (@(posedge clock) disable iff (reset)
      seq_ctl.op == OP_SHIFT || seq_ctl.op == OP_PLACE |-> dp_flag.gap_nz)
      else $error("insertion step with zero gap");

endmodule
`default_nettype wire

@@ dv/tb_shell_sort.sv @@
`timescale 1ns / 100ps
module tb_shell_sort;
   import ss_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int STIM_ITEMS   = 400;
   localparam int IDLE_LIMIT   = 20000;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 40;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef struct {
      value_type sorted_value;
      logic      final_res;
   } sorted_entry_type;

   // keeps the collected set, sorts it on the closing transaction and holds
   // the values the block has still to return
   class sort_board;
      value_type        held[];
      int unsigned      depth;
      int unsigned      count;
      sorted_entry_type pending_q[$];
      int               errors;

      function new(int unsigned d);
         depth  = d;
         held   = new[d];
         count  = 0;
         errors = 0;
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      // gapped insertion sort, gaps count/2 down to 1
      function void shell_pass();
         int unsigned gap, sub, i, pos;
         value_type   tmp;
         gap = count / 2;
         while (gap >= 1) begin
            for (sub = 0; sub < gap; sub++) begin
               for (i = gap + sub; i < count; i += gap) begin
                  tmp = held[i];
                  pos = i;
                  while (pos >= gap && held[pos - gap] > tmp) begin
                     held[pos] = held[pos - gap];
                     pos -= gap;
                  end
                  held[pos] = tmp;
               end
            end
            gap /= 2;
         end
      endfunction

      function void note_request(value_type v, logic closes);
         sorted_entry_type e;
         // store full: the value is dropped, the flag still counts
         if (count < depth) begin
            held[count] = v;
            count++;
         end
         if (closes) begin
            shell_pass();
            for (int unsigned k = 0; k < count; k++) begin
               e.sorted_value = held[k];
               e.final_res    = (k + 1 == count);
               pending_q.push_back(e);
            end
            count = 0;
         end
      endfunction

      task check_result(value_type v, logic f);
         sorted_entry_type e;
         if (pending_q.size() == 0) begin
            report($sformatf("result %0d final %0b with nothing expected", v, f));
         end else begin
            e = pending_q.pop_front();
            if (v !== e.sorted_value)
               report($sformatf("sorted_value %0d, expected %0d", v, e.sorted_value));
            if (f !== e.final_res)
               report($sformatf("final_res %0b, expected %0b (value %0d)",
                                f, e.final_res, e.sorted_value));
         end
      endtask

      function int outstanding();
         return pending_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ss_req_if req_if ();
   ss_rsp_if rsp_if ();

   shell_sort #(.CAPACITY(CAPACITY)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   sort_board board = new(CAPACITY);

   int  idle_cycles  = 0;
   bit  hold_request = 1'b0;
   bit  send_quiet   = 1'b0;
   int  items_sent   = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // transaction monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) board.note_request(req_if.value, req_if.last);
         if (rsp_if.valid && rsp_if.ready)
            board.check_result(rsp_if.sorted_value, rsp_if.final_res);
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic value_type draw_value();
      value_type v;
      case ($urandom_range(0, 4))
         0, 1: v = $urandom;
         2: v = $signed($urandom_range(0, 6)) - 3;  // many equal values
         3: v = ($urandom_range(0, 1) != 0) ? {1'b0, {(VALUE_W-1){1'b1}}} - $urandom_range(0, 2)
                                            : {1'b1, {(VALUE_W-1){1'b0}}} + $urandom_range(0, 2);
         default: v = $signed($urandom_range(0, 200)) - 100;
      endcase
      return v;
   endfunction

   task send_value(value_type v, logic closes);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
         @(negedge clock);
         req_if.valid = 1'b0;
      end
      @(negedge clock);
      req_if.valid = 1'b1;
      req_if.value = v;
      req_if.last  = closes;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   task send_set(value_type vals[$]);
      send_quiet = ($urandom_range(0, 3) == 0);
      foreach (vals[k]) send_value(vals[k], k == vals.size() - 1);
   endtask

   task send_random_set(int n);
      value_type vals[$];
      repeat (n) vals.push_back(draw_value());
      send_set(vals);
   endtask

   // result side: random ready gaps plus one long hold-off
   initial begin
      int  gap;
      int  served;
      bit  quiet;
      served = 0;
      quiet  = 1'b0;
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            @(negedge clock);
            rsp_if.ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         gap = quiet ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            @(negedge clock);
            rsp_if.ready = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_if.ready = 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         served++;
         if (served % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      value_type vmax, vmin;
      int        n;
      vmax = {1'b0, {(VALUE_W-1){1'b1}}};
      vmin = {1'b1, {(VALUE_W-1){1'b0}}};
      req_if.valid = 1'b0;
      req_if.value = '0;
      req_if.last  = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single-element sets, reversed pairs, equal values, mixed extremes, a descending run
      send_set('{vmin});
      send_set('{vmax});
      send_set('{vmax, vmin});
      send_set('{value_type'(5), value_type'(5), value_type'(5)});
      send_set('{vmax, value_type'(1), value_type'(0), value_type'(-1), vmin, vmax, vmin});
      send_set('{value_type'(8), value_type'(7), value_type'(6), value_type'(5),
                 value_type'(4), value_type'(3), value_type'(2), value_type'(1)});
      send_set('{value_type'(2), value_type'(-2)});

      // receiver stalls for a while so the block fills and backs up
      hold_request = 1'b1;
      send_random_set(CAPACITY + 4);   // overflow: extra values dropped
      send_random_set(CAPACITY);
      send_random_set(CAPACITY - 1);
      while (items_sent < STIM_ITEMS) begin
         n = ($urandom_range(0, 14) == 0) ? $urandom_range(CAPACITY - 4, CAPACITY + 6)
                                          : $urandom_range(1, 12);
         send_random_set(n);
      end
      @(negedge clock);
      req_if.valid = 1'b0;

      while (board.outstanding() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
